FILE: hw/rtl/dtw_sequence_similarity_unit_assert.svh
// ----------------------------------------------------------------------------
// DTW sequence similarity assertion macros
// Concurrent checks clocked by i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DTW_SEQUENCE_SIMILARITY_UNIT_ASSERT_SVH
`define DTW_SEQUENCE_SIMILARITY_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define DTWSS_CHECK(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication.
`define DTWSS_CHECK_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define DTWSS_CHECK(lbl, pre, post, msg)
`define DTWSS_CHECK_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: hw/rtl/dtwss_pkg.sv
// ----------------------------------------------------------------------------
// DTW sequence similarity package
// Field widths, fixed-point constants, the gamepad state type and the
// reciprocal table used by the local cost divider.
// ----------------------------------------------------------------------------
package dtwss_pkg;

    localparam int AXIS_W   = 16;
    localparam int TRIG_W   = 15;
    localparam int BTN_W    = 16;
    localparam int IDX_W    = 6;
    localparam int LEN_W    = 7;
    localparam int SIM_W    = 17;
    localparam int COL_W    = 26;
    localparam int COST_W   = 22;
    localparam int SUM_W    = 19;
    localparam int PCNT_W   = 5;
    localparam int XH_W     = 27;
    localparam int RCP_W    = 32;
    localparam int RCP_SH   = 34;
    localparam int COST_LAT = 4;

    localparam int BUTTON_COUNT = 16;

    localparam logic [COL_W-1:0]  COL_INF  = {COL_W{1'b1}};
    localparam logic [SIM_W-1:0]  SIM_ONE  = 17'h10000;
    localparam logic [SUM_W:0]    AXIS_ONE = 20'd16384;
    localparam logic [BTN_W-1:0]  BTN_MASK = BTN_W'((64'd1 << BUTTON_COUNT) - 64'd1);

    typedef struct packed {
        logic signed [AXIS_W-1:0] left_stick_x;
        logic signed [AXIS_W-1:0] left_stick_y;
        logic signed [AXIS_W-1:0] right_stick_x;
        logic signed [AXIS_W-1:0] right_stick_y;
        logic [TRIG_W-1:0]        left_trigger;
        logic [TRIG_W-1:0]        right_trigger;
        logic [BTN_W-1:0]         button_mask;
    } t_pad;

    // ceil(2^34 / (7*m)) for m = 1..16.
    function automatic logic [RCP_W-1:0] recip(input logic [PCNT_W-1:0] m);
        logic [RCP_W-1:0] r;
        case (m)
            5'd2:    r = 32'd1227133514;
            5'd3:    r = 32'd818089009;
            5'd4:    r = 32'd613566757;
            5'd5:    r = 32'd490853406;
            5'd6:    r = 32'd409044505;
            5'd7:    r = 32'd350609576;
            5'd8:    r = 32'd306783379;
            5'd9:    r = 32'd272696337;
            5'd10:   r = 32'd245426703;
            5'd11:   r = 32'd223115185;
            5'd12:   r = 32'd204522253;
            5'd13:   r = 32'd188789772;
            5'd14:   r = 32'd175304788;
            5'd15:   r = 32'd163617802;
            5'd16:   r = 32'd153391690;
            default: r = 32'd2454267027;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/dtwss_if.sv
// ----------------------------------------------------------------------------
// DTW sequence similarity channel interfaces
// Valid/ready channels for configuration, input items and result items.
// ----------------------------------------------------------------------------
interface dtwss_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dtwss_pkg::LEN_W-1:0]    pattern_length;

    modport source (output valid, output pattern_length, input ready);
    modport sink   (input valid, input pattern_length, output ready);
endinterface

interface dtwss_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   func;
    logic [dtwss_pkg::IDX_W-1:0]            entry_index;
    logic signed [dtwss_pkg::AXIS_W-1:0]    left_stick_x;
    logic signed [dtwss_pkg::AXIS_W-1:0]    left_stick_y;
    logic signed [dtwss_pkg::AXIS_W-1:0]    right_stick_x;
    logic signed [dtwss_pkg::AXIS_W-1:0]    right_stick_y;
    logic [dtwss_pkg::TRIG_W-1:0]           left_trigger;
    logic [dtwss_pkg::TRIG_W-1:0]           right_trigger;
    logic [dtwss_pkg::BTN_W-1:0]            button_mask;
    logic                                   last;

    modport source (output valid, output func, output entry_index, output left_stick_x,
                    output left_stick_y, output right_stick_x, output right_stick_y,
                    output left_trigger, output right_trigger, output button_mask,
                    output last, input ready);
    modport sink   (input valid, input func, input entry_index, input left_stick_x,
                    input left_stick_y, input right_stick_x, input right_stick_y,
                    input left_trigger, input right_trigger, input button_mask,
                    input last, output ready);
endinterface

interface dtwss_out_if;
    logic                           valid;
    logic                           ready;
    logic [dtwss_pkg::SIM_W-1:0]    similarity;
    logic                           overflow;

    modport source (output valid, output similarity, output overflow, input ready);
    modport sink   (input valid, input similarity, input overflow, output ready);
endinterface

FILE: hw/rtl/dtwss_cost.sv
// ----------------------------------------------------------------------------
// DTW local cost pipeline
// Four-stage cost of one pattern entry against one observed state, in Q.16.
// ----------------------------------------------------------------------------
module dtwss_cost (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  dtwss_pkg::t_pad                 i_pat,
    input  dtwss_pkg::t_pad                 i_obs,
    output logic                            o_valid,
    output logic [dtwss_pkg::COST_W-1:0]    o_cost
);

    function automatic logic [dtwss_pkg::AXIS_W-1:0] abs_axis(
        input logic signed [dtwss_pkg::AXIS_W-1:0] a,
        input logic signed [dtwss_pkg::AXIS_W-1:0] b
    );
        logic signed [dtwss_pkg::AXIS_W:0] d;
        d = {a[dtwss_pkg::AXIS_W-1], a} - {b[dtwss_pkg::AXIS_W-1], b};
        if (d[dtwss_pkg::AXIS_W]) begin
            d = -d;
        end
        return d[dtwss_pkg::AXIS_W-1:0];
    endfunction

    function automatic logic [dtwss_pkg::TRIG_W-1:0] abs_trig(
        input logic [dtwss_pkg::TRIG_W-1:0] a,
        input logic [dtwss_pkg::TRIG_W-1:0] b
    );
        logic [dtwss_pkg::TRIG_W-1:0] r;
        r = (a > b) ? (a - b) : (b - a);
        return r;
    endfunction

    // Stage 1: absolute differences and button counts.
    logic                               r_v1;
    logic [dtwss_pkg::AXIS_W-1:0]       r_ad [4];
    logic [dtwss_pkg::TRIG_W-1:0]       r_at [2];
    logic [dtwss_pkg::PCNT_W-1:0]       r_pc;
    logic [dtwss_pkg::PCNT_W-1:0]       r_oc;
    logic [dtwss_pkg::PCNT_W-1:0]       r_cc;
    logic [dtwss_pkg::BTN_W-1:0]        w_pb;
    logic [dtwss_pkg::BTN_W-1:0]        w_ob;

    assign w_pb = i_pat.button_mask & dtwss_pkg::BTN_MASK;
    assign w_ob = i_obs.button_mask & dtwss_pkg::BTN_MASK;

    always_ff @(posedge i_clk) begin
        r_ad[0] <= abs_axis(i_pat.left_stick_x, i_obs.left_stick_x);
        r_ad[1] <= abs_axis(i_pat.left_stick_y, i_obs.left_stick_y);
        r_ad[2] <= abs_axis(i_pat.right_stick_x, i_obs.right_stick_x);
        r_ad[3] <= abs_axis(i_pat.right_stick_y, i_obs.right_stick_y);
        r_at[0] <= abs_trig(i_pat.left_trigger, i_obs.left_trigger);
        r_at[1] <= abs_trig(i_pat.right_trigger, i_obs.right_trigger);
        r_pc    <= dtwss_pkg::PCNT_W'($countones(w_pb));
        r_oc    <= dtwss_pkg::PCNT_W'($countones(w_ob));
        r_cc    <= dtwss_pkg::PCNT_W'($countones(w_pb & w_ob));
    end

    // Stage 2: axis sum, larger pressed count and common count.
    logic                               r_v2;
    logic [dtwss_pkg::SUM_W-1:0]        r_sum;
    logic [dtwss_pkg::PCNT_W-1:0]       r_m;
    logic [dtwss_pkg::PCNT_W-1:0]       r_c;
    logic [dtwss_pkg::PCNT_W-1:0]       w_m;

    assign w_m = (r_pc > r_oc) ? r_pc : r_oc;

    always_ff @(posedge i_clk) begin
        r_sum <= dtwss_pkg::SUM_W'(r_ad[0]) + dtwss_pkg::SUM_W'(r_ad[1])
               + dtwss_pkg::SUM_W'(r_ad[2]) + dtwss_pkg::SUM_W'(r_ad[3])
               + dtwss_pkg::SUM_W'(r_at[0]) + dtwss_pkg::SUM_W'(r_at[1]);
        // With no button pressed on either side the button term counts as a match.
        if (w_m == '0) begin
            r_m <= dtwss_pkg::PCNT_W'(1);
            r_c <= dtwss_pkg::PCNT_W'(1);
        end else begin
            r_m <= w_m;
            r_c <= r_cc;
        end
    end

    // Stage 3: the cost is floor(xh / (7*m)) with xh = (8*num + 7*m) / 2.
    logic                               r_v3;
    logic [dtwss_pkg::XH_W-1:0]         r_xh;
    logic [dtwss_pkg::RCP_W-1:0]        r_rcp;
    logic [24:0]                        w_num;
    logic [27:0]                        w_x;

    always_comb begin
        w_num = 25'(r_m) * 25'(dtwss_pkg::AXIS_ONE + 20'(r_sum))
              - 25'(r_c) * 25'(dtwss_pkg::AXIS_ONE);
        w_x   = {w_num[24:0], 3'b000} + 28'(r_m) * 28'd7;
    end

    always_ff @(posedge i_clk) begin
        r_xh  <= w_x[27:1];
        r_rcp <= dtwss_pkg::recip(r_m);
    end

    // Stage 4: reciprocal product; the quotient sits above bit RCP_SH.
    logic                                           r_v4;
    logic [dtwss_pkg::XH_W+dtwss_pkg::RCP_W-1:0]    r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (dtwss_pkg::XH_W + dtwss_pkg::RCP_W)'(r_xh)
                * (dtwss_pkg::XH_W + dtwss_pkg::RCP_W)'(r_rcp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign o_valid = r_v4;
    assign o_cost  = r_prod[dtwss_pkg::RCP_SH+dtwss_pkg::COST_W-1:dtwss_pkg::RCP_SH];

endmodule

FILE: hw/rtl/dtwss_div.sv
// ----------------------------------------------------------------------------
// DTW restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtwss_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]    i_den,
    output logic                o_done,
    output logic [NUM_W-1:0]    o_quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [STEP_W-1:0]      r_step;
    logic [DEN_W-1:0]       r_den;
    logic [DEN_W-1:0]       r_rem;
    logic [NUM_W-1:0]       r_quo;
    logic [DEN_W:0]         w_trial;
    logic [DEN_W:0]         w_diff;
    logic                   w_fit;

    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: hw/rtl/dtw_sequence_similarity_unit.sv
// ----------------------------------------------------------------------------
// DTW sequence similarity unit
// Dynamic time warping between a stored gamepad pattern and a stream of
// observed gamepad states, reporting a Q1.16 similarity per sequence.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Carries
//  i_cfg    in   valid/ready   pattern_length (always ready)
//  i_obs    in   valid/ready   pattern writes (func=0) and observed states
//  o_res    out  valid/ready   similarity and overflow, once per sequence
//
// An observed state is worked over N warping cells, N being the pattern
// length in use: one warping cell enters the shared cost pipeline per
// cycle and its four stages drain at the end. The final state of a
// sequence then goes on to the read of the end cell and the bit-serial
// divider that forms the distance ratio; the divider is skipped when
// the pattern is empty or the end cell is unreachable.
// Reset is synchronous and needs no clearing pass: every warping cell has
// a valid bit, and a cell that is not valid reads as infinity.
// i_obs is not ready while an item is at work; a stalled o_res only holds
// the unit once a new result is ready to replace the one still waiting.
// ----------------------------------------------------------------------------
`include "dtw_sequence_similarity_unit_assert.svh"

module dtw_sequence_similarity_unit #(
    parameter int MAX_PATTERN  = 64,
    parameter int MAX_OBSERVED = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dtwss_cfg_if.sink       i_cfg,
    dtwss_in_if.sink        i_obs,
    dtwss_out_if.source     o_res
);

    // Address and counter widths follow from the sizes of the stores.
    localparam int AW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int NW    = $clog2(MAX_PATTERN + 1);
    localparam int CW    = $clog2(MAX_OBSERVED + 1);
    localparam int MAXM  = (MAX_PATTERN > MAX_OBSERVED) ? MAX_PATTERN : MAX_OBSERVED;
    localparam int MW    = $clog2(MAXM + 1);
    localparam int NUM_W = dtwss_pkg::COL_W + 2;
    localparam int DEN_W = MW + 1;
    localparam int LAT   = dtwss_pkg::COST_LAT;

    // Sequencer states.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_COL   = 6'b000010,
        S_FRD   = 6'b000100,
        S_FWAIT = 6'b001000,
        S_DIV   = 6'b010000,
        S_LOAD  = 6'b100000
    } t_state;

    t_state                         r_state;
    logic [dtwss_pkg::LEN_W-1:0]    r_len;
    dtwss_pkg::t_pad                r_obs;
    logic                           r_last;
    logic [NW-1:0]                  r_issue;
    logic [NW-1:0]                  r_wcnt;
    logic [CW-1:0]                  r_cnt;
    logic                           r_ovf;
    logic                           r_w0_zero;
    logic [dtwss_pkg::COL_W-1:0]    r_up;
    logic [dtwss_pkg::COL_W-1:0]    r_diag;
    logic [dtwss_pkg::SIM_W-1:0]    r_sim;

    logic                           r_res_vld;
    logic [dtwss_pkg::SIM_W-1:0]    r_res_sim;
    logic                           r_res_ovf;

    // ------------------------------------------------------------------
    // Configuration: the length register is always writable.
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg.valid) begin
            r_len <= i_cfg.pattern_length;
        end
    end

    // A length above the pattern store saturates at its depth.
    logic [NW-1:0] w_n;
    always_comb begin
        if (int'(r_len) > MAX_PATTERN) begin
            w_n = NW'(MAX_PATTERN);
        end else begin
            w_n = NW'(r_len);
        end
    end

    // ------------------------------------------------------------------
    // Input acceptance.
    // ------------------------------------------------------------------
    logic               w_acc;
    logic               w_acc_pat;
    logic               w_acc_obs;
    logic               w_seq_full;
    dtwss_pkg::t_pad    w_in_pad;

    assign i_obs.ready = (r_state == S_IDLE);
    assign w_acc       = i_obs.valid && i_obs.ready;
    assign w_acc_pat   = w_acc && !i_obs.func;
    assign w_acc_obs   = w_acc && i_obs.func;
    assign w_seq_full  = (int'(r_cnt) >= MAX_OBSERVED);

    always_comb begin
        w_in_pad.left_stick_x  = i_obs.left_stick_x;
        w_in_pad.left_stick_y  = i_obs.left_stick_y;
        w_in_pad.right_stick_x = i_obs.right_stick_x;
        w_in_pad.right_stick_y = i_obs.right_stick_y;
        w_in_pad.left_trigger  = i_obs.left_trigger;
        w_in_pad.right_trigger = i_obs.right_trigger;
        w_in_pad.button_mask   = i_obs.button_mask;
    end

    // ------------------------------------------------------------------
    // Pattern store. Entries beyond the store depth are dropped.
    // ------------------------------------------------------------------
    dtwss_pkg::t_pad    r_pat_mem [MAX_PATTERN];
    dtwss_pkg::t_pad    r_pat_q;
    logic [AW-1:0]      w_rd_addr;

    always_ff @(posedge i_clk) begin
        if (w_acc_pat && (int'(i_obs.entry_index) < MAX_PATTERN)) begin
            r_pat_mem[AW'(i_obs.entry_index)] <= w_in_pad;
        end
        r_pat_q <= r_pat_mem[w_rd_addr];
    end

    // ------------------------------------------------------------------
    // Warping column. Memory address k holds column row k+1; row 0 is
    // zero only at the start of a sequence and is kept as one flag.
    // ------------------------------------------------------------------
    logic [dtwss_pkg::COL_W-1:0]    r_col_mem [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]         r_col_vld;
    logic [dtwss_pkg::COL_W-1:0]    r_col_q;
    logic                           r_colv_q;
    logic [dtwss_pkg::COL_W-1:0]    w_col_rd;
    logic                           w_wr;
    logic [AW-1:0]                  w_wr_addr;
    logic [dtwss_pkg::COL_W-1:0]    w_wr_data;
    logic                           w_load;

    assign w_rd_addr = (r_state == S_FRD) ? AW'(w_n - NW'(1)) : AW'(r_issue);
    assign w_col_rd  = r_colv_q ? r_col_q : dtwss_pkg::COL_INF;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_col_mem[w_wr_addr] <= w_wr_data;
        end
        r_col_q  <= r_col_mem[w_rd_addr];
        r_colv_q <= r_col_vld[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_vld <= '0;
        end else if (w_load) begin
            r_col_vld <= '0;
        end else if (w_wr) begin
            r_col_vld[w_wr_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Cell issue and the shared cost pipeline. The left neighbour read
    // with each cell travels in a delay line matched to the pipeline.
    // ------------------------------------------------------------------
    logic                           w_issue;
    logic                           r_p0;
    logic [AW-1:0]                  r_p0_addr;
    logic                           w_cost_vld;
    logic [dtwss_pkg::COST_W-1:0]   w_cost;
    logic [dtwss_pkg::COL_W-1:0]    r_dl_left [LAT];
    logic [AW-1:0]                  r_dl_addr [LAT];

    assign w_issue = (r_state == S_COL) && (r_issue < w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0 <= 1'b0;
        end else begin
            r_p0 <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0_addr    <= AW'(r_issue);
        r_dl_left[0] <= w_col_rd;
        r_dl_addr[0] <= r_p0_addr;
        for (int k = 1; k < LAT; k++) begin
            r_dl_left[k] <= r_dl_left[k-1];
            r_dl_addr[k] <= r_dl_addr[k-1];
        end
    end

    dtwss_cost u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p0),
        .i_pat   (r_pat_q),
        .i_obs   (r_obs),
        .o_valid (w_cost_vld),
        .o_cost  (w_cost)
    );

    // Cell update: cost plus the smallest of up, left and diagonal,
    // saturated at infinity.
    logic [dtwss_pkg::COL_W-1:0]    w_left;
    logic [dtwss_pkg::COL_W-1:0]    w_best;
    logic [dtwss_pkg::COL_W:0]      w_sum;

    always_comb begin
        w_left = r_dl_left[LAT-1];
        w_best = (r_up < w_left) ? r_up : w_left;
        if (r_diag < w_best) begin
            w_best = r_diag;
        end
        w_sum = {1'b0, w_best} + (dtwss_pkg::COL_W + 1)'(w_cost);
        if (w_sum > {1'b0, dtwss_pkg::COL_INF}) begin
            w_wr_data = dtwss_pkg::COL_INF;
        end else begin
            w_wr_data = w_sum[dtwss_pkg::COL_W-1:0];
        end
    end

    assign w_wr      = w_cost_vld;
    assign w_wr_addr = r_dl_addr[LAT-1];

    // ------------------------------------------------------------------
    // Final ratio: floor((2d + mx) / (2mx)) rounds d / mx half up.
    // ------------------------------------------------------------------
    logic [MW-1:0]      w_mx;
    logic               w_div_start;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quot;
    logic [NUM_W-1:0]   w_div_num;
    logic [DEN_W-1:0]   w_div_den;
    logic               w_no_path;

    assign w_mx        = (MW'(w_n) > MW'(r_cnt)) ? MW'(w_n) : MW'(r_cnt);
    assign w_no_path   = (w_n == '0) || (w_col_rd == dtwss_pkg::COL_INF);
    assign w_div_start = (r_state == S_FWAIT) && !w_no_path;
    assign w_div_num   = {1'b0, w_col_rd, 1'b0} + NUM_W'(w_mx);
    assign w_div_den   = {w_mx, 1'b0};

    dtwss_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer and sequence bookkeeping.
    // ------------------------------------------------------------------
    assign w_load = (r_state == S_LOAD) && (!r_res_vld || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= '0;
            r_wcnt    <= '0;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_w0_zero <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc_obs) begin
                        if (w_seq_full) begin
                            // Past the sequence limit: state dropped, flag raised.
                            r_ovf   <= 1'b1;
                            r_state <= i_obs.last ? S_FRD : S_IDLE;
                        end else begin
                            r_cnt     <= r_cnt + CW'(1);
                            r_w0_zero <= 1'b0;
                            r_issue   <= '0;
                            r_wcnt    <= '0;
                            r_state   <= S_COL;
                        end
                    end
                end
                S_COL: begin
                    if (w_issue) begin
                        r_issue <= r_issue + NW'(1);
                    end
                    if (w_wr) begin
                        r_wcnt <= r_wcnt + NW'(1);
                    end
                    if (r_wcnt == w_n) begin
                        r_state <= r_last ? S_FRD : S_IDLE;
                    end
                end
                S_FRD: begin
                    r_state <= S_FWAIT;
                end
                S_FWAIT: begin
                    r_state <= w_no_path ? S_LOAD : S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (w_load) begin
                        r_cnt     <= '0;
                        r_ovf     <= 1'b0;
                        r_w0_zero <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Observed item, neighbour registers and the similarity value.
    always_ff @(posedge i_clk) begin
        if (w_acc_obs) begin
            r_obs  <= w_in_pad;
            r_last <= i_obs.last;
            r_up   <= dtwss_pkg::COL_INF;
            r_diag <= r_w0_zero ? '0 : dtwss_pkg::COL_INF;
        end else if (w_wr) begin
            r_up   <= w_wr_data;
            r_diag <= w_left;
        end
        if ((r_state == S_FWAIT) && w_no_path) begin
            r_sim <= '0;
        end else if (w_div_done) begin
            if (w_quot > NUM_W'(dtwss_pkg::SIM_ONE)) begin
                r_sim <= '0;
            end else begin
                r_sim <= dtwss_pkg::SIM_ONE - w_quot[dtwss_pkg::SIM_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (w_load) begin
            r_res_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res_sim <= r_sim;
            r_res_ovf <= r_ovf;
        end
    end

    assign o_res.valid      = r_res_vld;
    assign o_res.similarity = r_res_sim;
    assign o_res.overflow   = r_res_ovf;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `DTWSS_CHECK(a_wcnt_bound, (r_state == S_COL), (r_wcnt <= w_n), "cell count past length")
    `DTWSS_CHECK(a_cost_in_col, w_cost_vld, (r_state == S_COL), "cost result outside column")
    `DTWSS_CHECK(a_div_in_div, w_div_done, (r_state == S_DIV), "divider finished unexpectedly")
    `DTWSS_CHECK_NEXT(a_seq_clear, w_load, ((r_cnt == '0) && !r_ovf && r_w0_zero && (r_col_vld == '0)), "sequence not cleared after result")

endmodule
